>>> sv/spq_pkg.sv
// Shared constants, status codes and types of the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_OUT_W = 4;
  localparam int unsigned STATUS_W  = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [DATA_W-1:0] value;
  } spq_cmd_t;

  typedef struct packed {
    logic                     ge;
    logic signed [DATA_W-1:0] value;
  } spq_link_t;

endpackage
`default_nettype wire

>>> sv/spq_if.sv
// Valid/ready channel interfaces for commands and results of the queue.
`default_nettype none
interface spq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic signed [spq_pkg::DATA_W-1:0] item_value;

  modport source (output valid, output cmd, output item_value, input ready);
  modport sink (input valid, input cmd, input item_value, output ready);
endinterface

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::STATUS_W-1:0]        status;
  logic [spq_pkg::CNT_OUT_W-1:0]       count;
  logic                                head_valid;
  logic signed [spq_pkg::DATA_W-1:0]   head_value;

  modport source (output valid, output status, output count, output head_valid,
                  output head_value, input ready);
  modport sink (input valid, input status, input count, input head_valid,
                input head_value, output ready);
endinterface
`default_nettype wire

>>> sv/spq_cell.sv
// One place of the sorted store: holds an entry and trades it with its neighbors.
`default_nettype none
module spq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 4
) (
  input  wire logic                             clk_i,
  input  wire spq_pkg::spq_cmd_t                cmd_i,
  input  wire logic [CNT_W-1:0]                 count_i,
  input  wire logic                             found_i,
  input  wire spq_pkg::spq_link_t               left_i,
  input  wire logic signed [spq_pkg::DATA_W-1:0] right_value_i,
  output spq_pkg::spq_link_t                    link_o,
  output logic                                  match_o
);

  logic signed [spq_pkg::DATA_W-1:0] value_q;
  logic signed [spq_pkg::DATA_W-1:0] value_d;
  logic                              held;
  logic                              ge;
  logic                              le;

  assign held    = count_i > CNT_W'(IDX);
  assign ge      = !held || (cmd_i.value >= value_q);
  assign le      = held && (value_q <= cmd_i.value);
  assign match_o = held && (value_q == cmd_i.value);
  assign link_o  = '{ge: ge, value: value_q};

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (left_i.ge) begin
        value_d = left_i.value;
      end else if (ge) begin
        value_d = cmd_i.value;
      end
    end else if (cmd_i.del && found_i && le) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of entry cells and the result register.
//
//   Channel  Dir  Fields                                   Handshake
//   in_i     in   cmd, item_value                          valid/ready
//   out_o    out  status, count, head_valid, head_value    valid/ready
//
// The result of each accepted command appears in the next cycle.
// Every cell compares the command value with its own entry and shifts in
// parallel, so the whole store is updated together for any DEPTH.
// A new command is taken whenever the result register is empty or drained
// in the same cycle; a stalled output holds the store unchanged.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]                  cnt_q;
  logic [CNT_W-1:0]                  cnt_d;
  logic                              out_valid_q;
  logic [spq_pkg::STATUS_W-1:0]      status_q;
  logic [spq_pkg::STATUS_W-1:0]      status_d;
  logic                              accept;
  logic                              full;
  logic                              empty;
  logic                              found;
  logic [DEPTH-1:0]                  match;
  spq_pkg::spq_cmd_t                 cmd;
  spq_pkg::spq_link_t                link [DEPTH];

  assign accept = in_i.valid && in_i.ready;
  assign full   = cnt_q == CNT_W'(DEPTH);
  assign empty  = cnt_q == '0;
  assign found  = |match;

  assign cmd.ins   = accept && (in_i.cmd == spq_pkg::CMD_INSERT) && !full;
  assign cmd.del   = accept && (in_i.cmd == spq_pkg::CMD_DELETE) && found;
  assign cmd.value = in_i.item_value;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    spq_pkg::spq_link_t                left;
    logic signed [spq_pkg::DATA_W-1:0] right_value;

    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = link[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner_r
      assign right_value = link[k+1].value;
    end

    spq_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .count_i       (cnt_q),
      .found_i       (found),
      .left_i        (left),
      .right_value_i (right_value),
      .link_o        (link[k]),
      .match_o       (match[k])
    );
  end

  always_comb begin
    cnt_d    = cnt_q;
    status_d = spq_pkg::ST_OK;
    if (in_i.cmd == spq_pkg::CMD_INSERT) begin
      if (full) begin
        status_d = spq_pkg::ST_OVERFLOW;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else if (empty) begin
      status_d = spq_pkg::ST_EMPTY;
    end else if (!found) begin
      status_d = spq_pkg::ST_NOT_FOUND;
    end else begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= spq_pkg::ST_OK;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_i.ready       = !out_valid_q || out_o.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.count      = spq_pkg::CNT_OUT_W'(cnt_q);
  assign out_o.head_valid = !empty;
  assign out_o.head_value = empty ? '0 : link[0].value;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds the depth");

  a_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.cmd == spq_pkg::CMD_INSERT) && full
    |=> (status_q == spq_pkg::ST_OVERFLOW) && $stable(cnt_q))
    else $error("insert on a full queue did not report overflow");

  a_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.cmd == spq_pkg::CMD_DELETE) && empty
    |=> (status_q == spq_pkg::ST_EMPTY) && (cnt_q == '0))
    else $error("delete on an empty queue did not report empty");

  a_sorted_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= CNT_W'(2)) |-> (link[0].value >= link[1].value))
    else $error("head entry is smaller than the second entry");

endmodule
`default_nettype wire

>>> bench/tb_sorted_priority_queue.sv
// Self-checking testbench of the sorted priority queue with random stalls on both channels.
`timescale 1ns / 1ps
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEF;
  localparam int RANDOM_CMDS = 1330;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [CNT_OUT_W-1:0]     count;
    logic                     head_valid;
    logic signed [DATA_W-1:0] head_value;
  } spq_report_t;

  typedef struct {
    logic                     op;
    logic signed [DATA_W-1:0] value;
    bit                       wait_drain;
  } queue_cmd_t;

  logic clk_i;
  logic rst_ni;

  spq_in_if  in_if ();
  spq_out_if out_if ();

  sorted_priority_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  queue_cmd_t  cmd_backlog[$];
  spq_report_t due_reports[$];

  logic signed [DATA_W-1:0] store_vals[QDEPTH];
  int store_count = 0;

  int cmds_planned = 0;
  int cmds_sent = 0;
  int cmds_taken = 0;
  int reports_seen = 0;
  int errors = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic spq_report_t update_sorted_store(input logic op,
                                                      input logic signed [DATA_W-1:0] v);
    spq_report_t r;
    int pos;
    r.status = ST_OK;
    if (op == CMD_INSERT) begin
      if (store_count >= QDEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = store_count;
        for (int k = store_count - 1; k >= 0; k--) begin
          if (v >= store_vals[k]) pos = k;
        end
        for (int k = store_count; k > pos; k--) store_vals[k] = store_vals[k-1];
        store_vals[pos] = v;
        store_count++;
      end
    end else if (store_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pos = -1;
      for (int k = store_count - 1; k >= 0; k--) begin
        if (store_vals[k] == v) pos = k;
      end
      if (pos < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int k = pos; k + 1 < store_count; k++) store_vals[k] = store_vals[k+1];
        store_count--;
      end
    end
    r.count      = CNT_OUT_W'(store_count);
    r.head_valid = (store_count > 0);
    r.head_value = (store_count > 0) ? store_vals[0] : '0;
    return r;
  endfunction

  function automatic bit steady_phase();
    return reports_seen >= 600 && reports_seen < 900;
  endfunction

  task automatic plan_cmd(input logic op, input logic signed [DATA_W-1:0] v,
                          input bit wait_drain);
    queue_cmd_t c;
    c.op         = op;
    c.value      = v;
    c.wait_drain = wait_drain;
    cmd_backlog.push_back(c);
    cmds_planned++;
  endtask

  // The sender keeps an offered command steady until its transfer is seen.
  always @(negedge clk_i) begin : drive_cmds
    queue_cmd_t c;
    logic offer;
    if (rst_ni && !(in_if.valid && cmds_taken < cmds_sent)) begin
      offer = 1'b0;
      if (cmd_backlog.size() != 0 &&
          !(cmd_backlog[0].wait_drain && due_reports.size() != 0) &&
          (steady_phase() || $urandom_range(0, 99) >= 19)) begin
        offer = 1'b1;
        c = cmd_backlog.pop_front();
        in_if.cmd        <= c.op;
        in_if.item_value <= c.value;
        cmds_sent++;
      end
      in_if.valid <= offer;
    end
  end

  // A long hold-off lets the result register fill up and stall the input.
  always @(negedge clk_i) begin : drive_ready
    logic take;
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (!stall_done && reports_seen >= 300) begin
        stall_done = 1'b1;
        stall_left = 79;
        take = 1'b0;
      end else begin
        take = steady_phase() || $urandom_range(0, 99) >= 19;
      end
      out_if.ready <= take;
    end
  end

  always @(posedge clk_i) begin : check_reports
    spq_report_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        due_reports.push_back(update_sorted_store(in_if.cmd, in_if.item_value));
        cmds_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        reports_seen++;
        if (due_reports.size() == 0) begin
          $error("unexpected result transfer: status %0d count %0d", out_if.status,
                 out_if.count);
          errors++;
        end else begin
          want = due_reports.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            errors++;
          end
          if (out_if.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_if.count);
            errors++;
          end
          if (out_if.head_valid !== want.head_valid) begin
            $error("head_valid: expected %0d, got %0d", want.head_valid, out_if.head_valid);
            errors++;
          end
          if (out_if.head_value !== want.head_value) begin
            $error("head_value: expected %0d, got %0d", want.head_value, out_if.head_value);
            errors++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic signed [DATA_W-1:0] pool[6];
    logic signed [DATA_W-1:0] v;
    logic op;
    int burst_len;
    int ins_pct;
    bit noise;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_INSERT;
    in_if.item_value = '0;
    out_if.ready     = 1'b0;

    // Directed: empty, full, absent, duplicates and the value extremes.
    plan_cmd(CMD_DELETE, 5, 1'b0);
    plan_cmd(CMD_INSERT, 0, 1'b0);
    plan_cmd(CMD_INSERT, -1, 1'b0);
    plan_cmd(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
    plan_cmd(CMD_INSERT, 32'sh8000_0000, 1'b0);
    plan_cmd(CMD_INSERT, 0, 1'b0);
    plan_cmd(CMD_INSERT, 5, 1'b0);
    plan_cmd(CMD_INSERT, 7, 1'b0);
    plan_cmd(CMD_INSERT, 6, 1'b0);
    plan_cmd(CMD_INSERT, 1, 1'b0);
    plan_cmd(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
    plan_cmd(CMD_DELETE, 123, 1'b0);
    plan_cmd(CMD_DELETE, 0, 1'b0);
    plan_cmd(CMD_DELETE, 32'sh8000_0000, 1'b0);
    plan_cmd(CMD_DELETE, 32'sh7fff_ffff, 1'b0);
    plan_cmd(CMD_INSERT, -1, 1'b0);
    plan_cmd(CMD_DELETE, -1, 1'b0);
    plan_cmd(CMD_DELETE, -1, 1'b0);
    plan_cmd(CMD_DELETE, 0, 1'b0);
    plan_cmd(CMD_DELETE, 7, 1'b0);
    plan_cmd(CMD_DELETE, 6, 1'b0);
    plan_cmd(CMD_DELETE, 5, 1'b0);
    plan_cmd(CMD_DELETE, 5, 1'b1);

    // Random bursts that fill and drain the store with values from a small pool.
    while (cmds_planned < RANDOM_CMDS + 23) begin
      if ($urandom_range(0, 2) == 0 || cmds_planned == 23) begin
        foreach (pool[i]) begin
          pool[i] = $urandom_range(0, 1) ? $signed($urandom)
                                         : $signed(32'($urandom_range(0, 8)) - 32'd4);
        end
      end
      noise     = ($urandom_range(0, 99) < 15);
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0: ins_pct = 80;
        1: ins_pct = 25;
        default: ins_pct = 50;
      endcase
      for (int n = 0; n < burst_len; n++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
        if (noise || $urandom_range(0, 9) == 0) v = $signed($urandom);
        else v = pool[$urandom_range(0, 5)];
        plan_cmd(op, v, n == 0 && $urandom_range(0, 7) == 0);
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(cmds_taken == cmds_planned && due_reports.size() == 0)) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && due_reports.size() == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[sorted_priority_queue] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
